### design/tdq_pkg.sv
package tdq_pkg;

  localparam int unsigned DEADLINE_W = 48;
  localparam int unsigned HANDLE_W   = 4;
  localparam int unsigned DELAY_W    = 31;
  localparam int unsigned HORIZON_W  = 32;
  localparam int unsigned HANDLE_MAX = 16;

  // Command codes
  localparam logic [2:0] CMD_ARM     = 3'd0;
  localparam logic [2:0] CMD_CANCEL  = 3'd1;
  localparam logic [2:0] CMD_ADVANCE = 3'd2;
  localparam logic [2:0] CMD_POLL    = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_ARMED = 2'd3;

  localparam logic [HORIZON_W-1:0] HORIZON_RESET = 32'd18000000;

  typedef struct packed {
    logic [2:0]          command;
    logic [DELAY_W-1:0]  delay_ms;
    logic [HANDLE_W-1:0] target_handle;
  } tdq_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [HANDLE_W-1:0]   result_handle;
    logic [DEADLINE_W-1:0] result_deadline;
  } tdq_out_t;

  // Add two deadline-wide values, saturate at all ones
  function automatic logic [DEADLINE_W-1:0] sat_add(input logic [DEADLINE_W-1:0] a,
                                                     input logic [DEADLINE_W-1:0] b);
    logic [DEADLINE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DEADLINE_W] ? {DEADLINE_W{1'b1}} : sum[DEADLINE_W-1:0];
  endfunction

endpackage

### design/tdq_slot_mem.sv
module tdq_slot_mem #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [tdq_pkg::DEADLINE_W-1:0]    wdata,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [tdq_pkg::DEADLINE_W-1:0]    rdata
);

  logic [tdq_pkg::DEADLINE_W-1:0] mem [DEPTH];
  logic [tdq_pkg::DEADLINE_W-1:0] rdata_r;

  // Write one deadline
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; rdata updates only when re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/timer_deadline_queue_top.sv
// Channel | Ports                              | Transfer
// --------+------------------------------------+-------------------------------
// input   | start, busy, in_data (tdq_in_t)    | start high and busy low
// result  | out_valid, out_data (tdq_out_t)    | out_valid high, one cycle only
// config  | cfg_valid, cfg_ready, cfg_data     | cfg_valid and cfg_ready high
//
// Arm, advance and unused codes go via S_EXEC, cancel via S_CANCEL, poll and
// query via S_SCAN over min(SLOTS,16) slots and then S_FINISH: the scan reads
// one deadline per cycle from the single read port of the slot memory.
// Reset (rst_n low, synchronous) clears the clock, all armed bits and the
// result strobe; deadlines in memory are only used for armed slots.
// The receiver cannot stall; busy stays high until the result is driven.
module timer_deadline_queue_top #(
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  tdq_pkg::tdq_in_t                in_data,
  output logic                            out_valid,
  output tdq_pkg::tdq_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tdq_pkg::HORIZON_W-1:0]   cfg_data
);

  localparam int USED = (SLOTS < 16) ? SLOTS : 16;
  localparam int IW   = $clog2(USED);
  localparam logic [IW-1:0] LAST_IDX = IW'(USED - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CANCEL = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                          state_r, state_nxt;
  tdq_pkg::tdq_in_t                    cmd_r, cmd_nxt;
  logic [tdq_pkg::DEADLINE_W-1:0]      now_r, now_nxt;
  logic [tdq_pkg::HORIZON_W-1:0]       horizon_r, horizon_nxt;
  logic [USED-1:0]                     armed_r, armed_nxt;
  logic [IW-1:0]                       scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]                       best_idx_r, best_idx_nxt;
  logic [tdq_pkg::DEADLINE_W-1:0]      best_dl_r, best_dl_nxt;
  logic                                found_r, found_nxt;
  logic                                out_valid_r, out_valid_nxt;
  tdq_pkg::tdq_out_t                   out_data_r, out_data_nxt;

  logic                                accept;
  logic                                mem_we;
  logic [IW-1:0]                       mem_waddr;
  logic [tdq_pkg::DEADLINE_W-1:0]      mem_wdata;
  logic                                mem_re;
  logic [IW-1:0]                       mem_raddr;
  logic [tdq_pkg::DEADLINE_W-1:0]      mem_rdata;
  logic                                free_found;
  logic [IW-1:0]                       free_idx;
  logic [tdq_pkg::DEADLINE_W-1:0]      arm_dl;
  logic                                tgt_in_range;
  logic [IW-1:0]                       tgt_idx;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign arm_dl       = tdq_pkg::sat_add(now_r, tdq_pkg::DEADLINE_W'(cmd_r.delay_ms));
  assign tgt_in_range = ({1'b0, cmd_r.target_handle} < 5'(USED));
  assign tgt_idx      = cmd_r.target_handle[IW-1:0];

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = USED - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Drive the read port: cancel target or scan address
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (accept) begin
      mem_re    = 1'b1;
      mem_raddr = (in_data.command == tdq_pkg::CMD_CANCEL) ?
                  in_data.target_handle[IW-1:0] : '0;
    end else if (state_r == S_SCAN && scan_idx_r != LAST_IDX) begin
      mem_re    = 1'b1;
      mem_raddr = scan_idx_r + 1'b1;
    end
  end

  // Sequence one command at a time
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    horizon_nxt   = horizon_r;
    armed_nxt     = armed_r;
    scan_idx_nxt  = scan_idx_r;
    best_idx_nxt  = best_idx_r;
    best_dl_nxt   = best_dl_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = free_idx;
    mem_wdata     = arm_dl;

    if (cfg_valid && cfg_ready) begin
      horizon_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_data;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          best_idx_nxt = '0;
          if (in_data.command == tdq_pkg::CMD_CANCEL) begin
            state_nxt = S_CANCEL;
          end else if (in_data.command == tdq_pkg::CMD_POLL ||
                       in_data.command == tdq_pkg::CMD_QUERY) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        out_data_nxt  = '{status: tdq_pkg::ST_NONE, result_handle: '0, result_deadline: '0};
        if (cmd_r.command == tdq_pkg::CMD_ARM) begin
          if (free_found) begin
            mem_we              = 1'b1;
            armed_nxt[free_idx] = 1'b1;
            out_data_nxt = '{status: tdq_pkg::ST_OK,
                             result_handle: tdq_pkg::HANDLE_W'(free_idx),
                             result_deadline: arm_dl};
          end else begin
            out_data_nxt.status = tdq_pkg::ST_FULL;
          end
        end else if (cmd_r.command == tdq_pkg::CMD_ADVANCE) begin
          now_nxt      = arm_dl;
          out_data_nxt = '{status: tdq_pkg::ST_OK, result_handle: '0,
                           result_deadline: arm_dl};
        end
      end
      S_CANCEL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (tgt_in_range && armed_r[tgt_idx]) begin
          armed_nxt[tgt_idx] = 1'b0;
          out_data_nxt = '{status: tdq_pkg::ST_OK, result_handle: cmd_r.target_handle,
                           result_deadline: mem_rdata};
        end else begin
          out_data_nxt = '{status: tdq_pkg::ST_NOT_ARMED,
                           result_handle: cmd_r.target_handle, result_deadline: '0};
        end
      end
      S_SCAN: begin
        // Keep the earliest armed deadline; strict compare keeps lowest handle
        if (armed_r[scan_idx_r] && (!found_r || mem_rdata < best_dl_r)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = scan_idx_r;
          best_dl_nxt  = mem_rdata;
        end
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_FINISH;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_FINISH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        out_data_nxt  = '{status: tdq_pkg::ST_NONE, result_handle: '0, result_deadline: '0};
        if (cmd_r.command == tdq_pkg::CMD_POLL) begin
          if (found_r && best_dl_r <= now_r) begin
            armed_nxt[best_idx_r] = 1'b0;
            out_data_nxt = '{status: tdq_pkg::ST_OK,
                             result_handle: tdq_pkg::HANDLE_W'(best_idx_r),
                             result_deadline: best_dl_r};
          end
        end else if (found_r) begin
          out_data_nxt = '{status: tdq_pkg::ST_OK,
                           result_handle: tdq_pkg::HANDLE_W'(best_idx_r),
                           result_deadline: best_dl_r};
        end else begin
          out_data_nxt.result_deadline =
            tdq_pkg::sat_add(now_r, tdq_pkg::DEADLINE_W'(horizon_r));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      horizon_r   <= tdq_pkg::HORIZON_RESET;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      horizon_r   <= horizon_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    scan_idx_r <= scan_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  tdq_slot_mem #(
    .DEPTH (USED)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
